// ----- sv/equi_depth_bucket_builder_macros.svh -----
// assertion macros for the equi-depth bucket builder checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef EQUI_DEPTH_BUCKET_BUILDER_MACROS_SVH
`define EQUI_DEPTH_BUCKET_BUILDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define EDB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define EDB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/edb_pkg.sv -----
// shared types, constants and helpers of the equi-depth bucket builder
// no dependencies
package edb_pkg;

    localparam int FIELD_W  = 32;
    localparam int BT_W     = 11;
    localparam int ADDR_W   = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [FIELD_W-1:0] WISH_RESET  = 32'd1;
    localparam logic [BT_W-1:0]    TOTAL_RESET = 11'd16;

    // register index, taken from paddr[2]
    localparam logic REG_WISH_DEPTH   = 1'b0;
    localparam logic REG_BUCKET_TOTAL = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] wish_depth;
        logic [BT_W-1:0]    bucket_total;
    } t_cfg;

    typedef struct packed {
        logic signed [FIELD_W-1:0] value;
        logic [FIELD_W-1:0]        count;
        logic                      last;
    } t_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] lo;
        logic signed [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0]        freq;
        logic [FIELD_W-1:0]        distinct;
        logic                      run_end;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    slot0;
        t_result    slot1;
    } t_step;

    function automatic logic [FIELD_W-1:0] sat32(input logic [FIELD_W:0] x);
        return x[FIELD_W] ? '1 : x[FIELD_W-1:0];
    endfunction

endpackage

// ----- sv/edb_regs.sv -----
// apb configuration registers: wished depth and bucket total
// depends on edb_pkg
module edb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [edb_pkg::ADDR_W-1:0]        paddr,
    input  logic [edb_pkg::FIELD_W-1:0]       pwdata,
    output logic [edb_pkg::FIELD_W-1:0]       prdata,
    output logic                              pready,
    output edb_pkg::t_cfg                     o_cfg
);

    logic [edb_pkg::FIELD_W-1:0] r_wish;
    logic [edb_pkg::BT_W-1:0]    r_total;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wish  <= edb_pkg::WISH_RESET;
            r_total <= edb_pkg::TOTAL_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                edb_pkg::REG_WISH_DEPTH:   r_wish  <= pwdata;
                edb_pkg::REG_BUCKET_TOTAL: r_total <= pwdata[edb_pkg::BT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            edb_pkg::REG_WISH_DEPTH:   prdata = r_wish;
            edb_pkg::REG_BUCKET_TOTAL: prdata = edb_pkg::FIELD_W'(r_total);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.wish_depth   = r_wish;
    assign o_cfg.bucket_total = r_total;

endmodule

// ----- sv/edb_core.sv -----
// open-bucket state and the per-item close decision
// depends on edb_pkg
module edb_core #(
    parameter int VALUE_BITS  = 32,
    parameter int MAX_BUCKETS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  edb_pkg::t_item i_item,
    input  edb_pkg::t_cfg  i_cfg,
    output edb_pkg::t_step o_step
);

    localparam int VW = VALUE_BITS;
    localparam int OW = (VW < edb_pkg::FIELD_W) ? VW : edb_pkg::FIELD_W;
    localparam int CW = $clog2(MAX_BUCKETS + 1);
    localparam int EW = ((CW > edb_pkg::BT_W) ? CW : edb_pkg::BT_W) + 1;
    localparam int FW = edb_pkg::FIELD_W;

    logic [VW-1:0] r_lo, r_hi;
    logic [FW-1:0] r_freq, r_dist;
    logic          r_open;
    logic [CW-1:0] r_closed;

    logic [VW-1:0] n_lo, n_hi;
    logic [FW-1:0] n_freq, n_dist;
    logic          n_open;
    logic [CW-1:0] n_closed;

    logic [VW-1:0] vw;
    logic [FW-1:0] cnt, wish, dist_inc, freq_sum;
    logic [FW:0]   upper;
    logic [EW-1:0] bt_e, max_e, eff;
    logic [CW-1:0] closed_inc, closed_inc2;
    logic          rem_a, rem_b, cnt_ge, split;
    logic          e1, e2, el;
    edb_pkg::t_result res1, res2, resl;

    function automatic edb_pkg::t_result mk(input logic [VW-1:0] lo, input logic [VW-1:0] hi,
                                           input logic [FW-1:0] f, input logic [FW-1:0] d);
        edb_pkg::t_result r;
        r.lo       = FW'(lo[OW-1:0]);
        r.hi       = FW'(hi[OW-1:0]);
        r.freq     = f;
        r.distinct = d;
        r.run_end  = 1'b0;
        return r;
    endfunction

    assign vw   = VW'(i_item.value);
    assign cnt  = i_item.count;
    assign wish = (i_cfg.wish_depth == '0) ? FW'(1) : i_cfg.wish_depth;

    assign bt_e  = EW'(i_cfg.bucket_total);
    assign max_e = EW'(MAX_BUCKETS);
    assign eff   = (bt_e == '0) ? EW'(1) : ((bt_e > max_e) ? max_e : bt_e);

    assign closed_inc  = (r_closed < CW'(MAX_BUCKETS)) ? CW'(r_closed + CW'(1)) : r_closed;
    assign closed_inc2 = (closed_inc < CW'(MAX_BUCKETS)) ? CW'(closed_inc + CW'(1)) : closed_inc;
    assign rem_a = (EW'(r_closed) + EW'(1)) >= eff;
    assign rem_b = (EW'(closed_inc) + EW'(1)) >= eff;

    assign upper    = {1'b0, r_freq} + {1'b0, cnt};
    assign freq_sum = edb_pkg::sat32(upper);
    assign dist_inc = (r_dist == '1) ? r_dist : FW'(r_dist + FW'(1));
    assign cnt_ge   = cnt >= wish;
    assign split    = (upper > {1'b0, wish}) && (r_freq <= wish)
                   && ({1'b0, FW'(wish - r_freq)} < FW'(upper - {1'b0, wish}) + (FW+1)'(0)
                       || ({1'b0, FW'(wish - r_freq)} < (upper - {1'b0, wish})));

    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_freq   = r_freq;
        n_dist   = r_dist;
        n_open   = r_open;
        n_closed = r_closed;
        e1       = 1'b0;
        e2       = 1'b0;
        res1     = mk(vw, vw, cnt, FW'(1));
        res2     = mk(vw, vw, cnt, FW'(1));
        if (!r_open) begin
            n_open = 1'b1;
            n_lo   = vw;
            n_hi   = vw;
            n_freq = cnt;
            n_dist = FW'(1);
            if (!rem_a && cnt_ge) begin
                e1       = 1'b1;
                n_open   = 1'b0;
                n_closed = closed_inc;
            end
        end else if (rem_a || (upper < {1'b0, wish})) begin
            n_hi   = vw;
            n_freq = freq_sum;
            n_dist = dist_inc;
        end else if (split) begin
            e1       = 1'b1;
            res1     = mk(r_lo, r_hi, r_freq, r_dist);
            n_closed = closed_inc;
            n_open   = 1'b1;
            n_lo     = vw;
            n_hi     = vw;
            n_freq   = cnt;
            n_dist   = FW'(1);
            if (!rem_b && cnt_ge) begin
                e2       = 1'b1;
                n_open   = 1'b0;
                n_closed = closed_inc2;
            end
        end else begin
            e1       = 1'b1;
            res1     = mk(r_lo, vw, freq_sum, dist_inc);
            n_open   = 1'b0;
            n_closed = closed_inc;
            n_hi     = vw;
            n_freq   = freq_sum;
            n_dist   = dist_inc;
        end
    end

    assign el   = i_item.last && n_open;
    assign resl = mk(n_lo, n_hi, n_freq, n_dist);

    always_comb begin
        o_step.num   = 2'(e1) + 2'(e2) + 2'(el);
        o_step.slot0 = e1 ? res1 : resl;
        o_step.slot1 = e2 ? res2 : resl;
        o_step.slot0.run_end = (o_step.num == 2'd1);
        o_step.slot1.run_end = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= '0;
            r_hi     <= '0;
            r_freq   <= '0;
            r_dist   <= '0;
            r_open   <= 1'b0;
            r_closed <= '0;
        end else if (i_go) begin
            if (i_item.last) begin
                r_lo     <= '0;
                r_hi     <= '0;
                r_freq   <= '0;
                r_dist   <= '0;
                r_open   <= 1'b0;
                r_closed <= '0;
            end else begin
                r_lo     <= n_lo;
                r_hi     <= n_hi;
                r_freq   <= n_freq;
                r_dist   <= n_dist;
                r_open   <= n_open;
                r_closed <= n_closed;
            end
        end
    end

endmodule

// ----- sv/edb_outq.sv -----
// four-entry result queue: takes up to two results a cycle, hands out one
// while i_out_stall is low; depends on edb_pkg
module edb_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  edb_pkg::t_step   i_step,
    input  logic             i_push,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output edb_pkg::t_result o_head,
    output logic             o_room
);

    edb_pkg::t_result            r_q [edb_pkg::Q_DEPTH];
    logic [edb_pkg::Q_PTR_W-1:0] r_wr, r_rd;
    logic [edb_pkg::Q_CNT_W-1:0] r_cnt;
    logic [1:0]                  num;
    logic                        pop;
    logic [edb_pkg::Q_PTR_W-1:0] wr_next;

    assign num     = i_push ? i_step.num : 2'd0;
    assign pop     = (r_cnt != '0) && !i_out_stall;
    assign wr_next = edb_pkg::Q_PTR_W'(r_wr + edb_pkg::Q_PTR_W'(1));

    assign o_out_valid = (r_cnt != '0);
    assign o_head      = r_q[r_rd];
    assign o_room      = r_cnt <= edb_pkg::Q_CNT_W'(edb_pkg::Q_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (num != 2'd0) begin
            r_q[r_wr] <= i_step.slot0;
        end
        if (num == 2'd2) begin
            r_q[wr_next] <= i_step.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= edb_pkg::Q_PTR_W'(r_wr + edb_pkg::Q_PTR_W'(num));
            r_rd  <= edb_pkg::Q_PTR_W'(r_rd + edb_pkg::Q_PTR_W'(pop));
            r_cnt <= edb_pkg::Q_CNT_W'(r_cnt + edb_pkg::Q_CNT_W'(num) - edb_pkg::Q_CNT_W'(pop));
        end
    end

endmodule

// ----- sv/equi_depth_bucket_builder.sv -----
// Equi-depth bucket builder. Sorted (value, count) items enter on the input
// channel, one per cycle; each is registered, then the open bucket is updated
// and zero, one or two finished buckets are written into a four-entry result
// queue. The queue hands out one bucket per cycle while i_out_stall is low; an
// item that closes two buckets pushes both at once, and the input stalls while
// fewer than two queue slots are free. Sustained rate is one item per cycle as
// long as buckets are taken as fast as they close. wish_depth (0 reads as 1)
// and bucket_total (clamped to 1..MAX_BUCKETS) are written over APB at byte
// addresses 0 and 4; the user must write them only while the block is idle,
// which the block does not enforce. An item with item_last set closes the open
// bucket and clears all bucket state for the next range.
// depends on edb_pkg, edb_regs, edb_core, edb_outq
module equi_depth_bucket_builder #(
    parameter int VALUE_BITS  = 32,
    parameter int MAX_BUCKETS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [edb_pkg::ADDR_W-1:0]         paddr,
    input  logic [edb_pkg::FIELD_W-1:0]        pwdata,
    output logic [edb_pkg::FIELD_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [edb_pkg::FIELD_W-1:0] i_item_value,
    input  logic [edb_pkg::FIELD_W-1:0]        i_item_count,
    input  logic                               i_item_last,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [edb_pkg::FIELD_W-1:0] o_out_lo,
    output logic signed [edb_pkg::FIELD_W-1:0] o_out_hi,
    output logic [edb_pkg::FIELD_W-1:0]        o_out_freq,
    output logic [edb_pkg::FIELD_W-1:0]        o_out_distinct,
    output logic                               o_run_end
);

    edb_pkg::t_cfg    cfg;
    edb_pkg::t_item   r_item;
    edb_pkg::t_step   step;
    edb_pkg::t_result head;
    logic             r_in_vld;
    logic             go, room, accept;

    edb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign go         = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.value <= i_item_value;
            r_item.count <= i_item_count;
            r_item.last  <= i_item_last;
        end
    end

    edb_core #(
        .VALUE_BITS  (VALUE_BITS),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_step  (step)
    );

    edb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_push      (go),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_head      (head),
        .o_room      (room)
    );

    assign o_out_lo       = head.lo;
    assign o_out_hi       = head.hi;
    assign o_out_freq     = head.freq;
    assign o_out_distinct = head.distinct;
    assign o_run_end      = head.run_end;

endmodule

// ----- sv/edb_chk.sv -----
// port-level checker for the equi-depth bucket builder, bound to the top level
// depends on equi_depth_bucket_builder_macros.svh and edb_pkg
`include "equi_depth_bucket_builder_macros.svh"

module edb_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic signed [edb_pkg::FIELD_W-1:0] o_out_lo,
    input logic signed [edb_pkg::FIELD_W-1:0] o_out_hi,
    input logic [edb_pkg::FIELD_W-1:0]        o_out_distinct,
    input logic                               o_run_end
);

    // a stalled bucket transfer keeps its bounds and run-end flag
    `EDB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_lo) && $stable(o_out_hi) && $stable(o_run_end), "stalled result changed")

    // both buckets of one item are queued together
    `EDB_ASSERT_NEXT(a_pair_follows, o_out_valid && !i_out_stall && !o_run_end, o_out_valid, "second result of an item missing")

    // an emitted bucket always holds at least one value
    `EDB_ASSERT_SAME(a_distinct_nonzero, o_out_valid, o_out_distinct != '0, "empty bucket emitted")

    // a single-value bucket has equal bounds
    `EDB_ASSERT_SAME(a_single_bounds, o_out_valid && (o_out_distinct == 32'd1), o_out_lo == o_out_hi, "single-value bucket bounds differ")

endmodule

bind equi_depth_bucket_builder edb_chk u_edb_chk (.*);

// ----- verif/equi_depth_bucket_builder_test.sv -----
// self-checking testbench for equi_depth_bucket_builder: (value, count) ranges
// go in, each finished bucket is compared with a local bucket predictor
// depends on edb_pkg and the equi_depth_bucket_builder rtl
`timescale 1ns / 100ps

module equi_depth_bucket_builder_test;

    localparam int MAX_BKT      = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 37;
    localparam int MAX_SHOWN    = 10;

    localparam logic [edb_pkg::ADDR_W-1:0] WISH_ADDR  = {edb_pkg::REG_WISH_DEPTH, 2'b00};
    localparam logic [edb_pkg::ADDR_W-1:0] TOTAL_ADDR = {edb_pkg::REG_BUCKET_TOTAL, 2'b00};

    localparam logic signed [edb_pkg::FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [edb_pkg::FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic [edb_pkg::FIELD_W-1:0]        CNT_MAX = 32'hFFFF_FFFF;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [edb_pkg::ADDR_W-1:0]         paddr;
    logic [edb_pkg::FIELD_W-1:0]        pwdata;
    logic [edb_pkg::FIELD_W-1:0]        prdata;
    logic                               pready;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [edb_pkg::FIELD_W-1:0] i_item_value;
    logic [edb_pkg::FIELD_W-1:0]        i_item_count;
    logic                               i_item_last;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [edb_pkg::FIELD_W-1:0] o_out_lo;
    logic signed [edb_pkg::FIELD_W-1:0] o_out_hi;
    logic [edb_pkg::FIELD_W-1:0]        o_out_freq;
    logic [edb_pkg::FIELD_W-1:0]        o_out_distinct;
    logic                               o_run_end;

    // predictor copy of registers and open bucket
    edb_pkg::t_cfg                      cfg;
    logic signed [edb_pkg::FIELD_W-1:0] cur_lo;
    logic signed [edb_pkg::FIELD_W-1:0] cur_hi;
    logic [63:0]                        cur_freq;
    logic [63:0]                        cur_distinct;
    logic                               cur_open;
    int                                 n_closed;
    edb_pkg::t_result                   step_buf [2];
    int                                 step_n;
    edb_pkg::t_result                   pending_buckets [$];

    edb_pkg::t_result seen_bucket;
    edb_pkg::t_result want_bucket;
    bit      idle_on;
    int      cycle_count     = 0;
    int      error_count     = 0;
    int      items_sent      = 0;
    int      ranges_sent     = 0;
    int      buckets_checked = 0;
    int      config_writes   = 0;

    equi_depth_bucket_builder #(
        .VALUE_BITS (32),
        .MAX_BUCKETS(MAX_BKT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item_value  (i_item_value),
        .i_item_count  (i_item_count),
        .i_item_last   (i_item_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_lo      (o_out_lo),
        .o_out_hi      (o_out_hi),
        .o_out_freq    (o_out_freq),
        .o_out_distinct(o_out_distinct),
        .o_run_end     (o_run_end)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d buckets still due",
                     cycle_count, pending_buckets.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic logic [31:0] clip32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic bit in_last_bucket();
        int eff;
        eff = int'(cfg.bucket_total);
        if (eff == 0)
            eff = 1;
        if (eff > MAX_BKT)
            eff = MAX_BKT;
        return (n_closed + 1) >= eff;
    endfunction

    function automatic string fmt_bucket(input edb_pkg::t_result b);
        return $sformatf("lo=%0d hi=%0d freq=%0d distinct=%0d end=%0b",
                         b.lo, b.hi, b.freq, b.distinct, b.run_end);
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic retire_bucket();
        step_buf[step_n].lo       = cur_lo;
        step_buf[step_n].hi       = cur_hi;
        step_buf[step_n].freq     = clip32(cur_freq);
        step_buf[step_n].distinct = clip32(cur_distinct);
        step_buf[step_n].run_end  = 1'b0;
        step_n++;
        cur_open = 1'b0;
        if (n_closed < MAX_BKT)
            n_closed++;
    endtask

    task automatic open_bucket(input logic signed [31:0] value, input logic [63:0] c,
                               input logic [63:0] wish);
        cur_open     = 1'b1;
        cur_lo       = value;
        cur_hi       = value;
        cur_freq     = c;
        cur_distinct = 64'd1;
        if (!in_last_bucket() && c >= wish)
            retire_bucket();
    endtask

    task automatic absorb(input logic signed [31:0] value, input logic [63:0] c);
        cur_hi       = value;
        cur_freq     = {32'd0, clip32(cur_freq + c)};
        cur_distinct = {32'd0, clip32(cur_distinct + 64'd1)};
    endtask

    task automatic fold_item(input logic signed [31:0] value, input logic [31:0] count,
                             input logic is_last);
        logic [63:0] wish;
        logic [63:0] c;
        logic [63:0] upper;
        step_n = 0;
        wish   = (cfg.wish_depth == 0) ? 64'd1 : {32'd0, cfg.wish_depth};
        c      = {32'd0, count};
        if (!cur_open) begin
            open_bucket(value, c, wish);
        end else if (in_last_bucket()) begin
            absorb(value, c);
        end else begin
            upper = cur_freq + c;
            if (upper < wish) begin
                absorb(value, c);
            end else if (upper > wish && (wish - cur_freq) < (upper - wish)) begin
                retire_bucket();
                open_bucket(value, c, wish);
            end else begin
                absorb(value, c);
                cur_freq = upper;
                retire_bucket();
            end
        end
        if (is_last) begin
            if (cur_open)
                retire_bucket();
            cur_lo       = '0;
            cur_hi       = '0;
            cur_freq     = '0;
            cur_distinct = '0;
            cur_open     = 1'b0;
            n_closed     = 0;
        end
        if (step_n > 0)
            step_buf[step_n-1].run_end = 1'b1;
        for (int k = 0; k < step_n; k++)
            pending_buckets = {pending_buckets, step_buf[k]};
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_bucket.lo       = o_out_lo;
            seen_bucket.hi       = o_out_hi;
            seen_bucket.freq     = o_out_freq;
            seen_bucket.distinct = o_out_distinct;
            seen_bucket.run_end  = o_run_end;
            if (pending_buckets.size() == 0) begin
                note_failure({"unexpected bucket ", fmt_bucket(seen_bucket)});
            end else begin
                want_bucket = pending_buckets.pop_front();
                buckets_checked++;
                if (seen_bucket !== want_bucket)
                    note_failure($sformatf("bucket %0d expected %s got %s", buckets_checked,
                                           fmt_bucket(want_bucket), fmt_bucket(seen_bucket)));
            end
        end
    end

    task automatic send_item(input logic signed [31:0] value, input logic [31:0] count,
                             input logic is_last);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_item_value <= value;
        i_item_count <= count;
        i_item_last  <= is_last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        fold_item(value, count, is_last);
        items_sent++;
        if (is_last)
            ranges_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_buckets.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [edb_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WISH_ADDR)
            cfg.wish_depth = data;
        else
            cfg.bucket_total = data[edb_pkg::BT_W-1:0];
        config_writes++;
    endtask

    task automatic set_config(input logic [31:0] wish, input logic [31:0] total);
        wait_idle();
        apb_write(WISH_ADDR, wish);
        apb_write(TOTAL_ADDR, total);
    endtask

    task automatic test_reset_defaults();
        send_item(-5, 0, 1'b0);
        send_item(-2, 3, 1'b0);
        send_item(7, 1, 1'b0);
        send_item(9, 0, 1'b1);
    endtask

    task automatic test_field_extremes();
        set_config(32'hFFFF_FFFF, 1024);
        send_item(VAL_MIN, 0, 1'b0);
        send_item(0, CNT_MAX, 1'b0);
        send_item(VAL_MAX, CNT_MAX, 1'b0);
        send_item(VAL_MAX, 0, 1'b1);
    endtask

    task automatic test_saturation();
        set_config(5, 1);
        send_item(1, CNT_MAX, 1'b0);
        send_item(2, CNT_MAX, 1'b0);
        send_item(3, 7, 1'b1);
    endtask

    task automatic test_zero_settings();
        set_config(0, 0);
        send_item(10, 0, 1'b0);
        send_item(11, 2, 1'b0);
        send_item(12, 0, 1'b1);
        set_config(0, 5);
        send_item(20, 0, 1'b0);
        send_item(21, 0, 1'b0);
        send_item(22, 1, 1'b1);
    endtask

    task automatic test_overshoot_rules();
        set_config(10, 8);
        // tie in closeness keeps the item
        send_item(1, 7, 1'b0);
        send_item(2, 6, 1'b0);
        // closer without the item, item opens the next bucket
        send_item(3, 9, 1'b0);
        send_item(4, 5, 1'b0);
        send_item(5, 2, 1'b0);
        // early close plus an item that fills a bucket by itself
        send_item(6, 20, 1'b0);
        send_item(7, 4, 1'b1);
    endtask

    task automatic test_unsorted_input();
        set_config(6, 4);
        send_item(100, 2, 1'b0);
        send_item(50, 2, 1'b0);
        send_item(-30, 3, 1'b1);
    endtask

    task automatic test_bucket_clamp();
        int k;
        set_config(1, 2047);
        for (k = 0; k < 24; k++)
            send_item(k, 1, k == 23);
    endtask

    task automatic test_random_ranges();
        int                 round;
        int                 k;
        int                 roll;
        logic [31:0]        wish;
        logic [31:0]        weff;
        logic [31:0]        total;
        logic [31:0]        count;
        logic signed [31:0] value;
        logic               is_last;
        for (round = 0; round < 9; round++) begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                wish = $urandom;
            else if (roll == 1)
                wish = $urandom_range(0, 1);
            else
                wish = $urandom_range(2, 64);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                total = $urandom;
            else if (roll == 1)
                total = 0;
            else
                total = $urandom_range(1, 12);
            set_config(wish, total);
            weff    = (wish == 0) ? 32'd1 : wish;
            // quiet stretch with no idling on either side
            idle_on = !(round == 4 || round == 5);
            value   = $urandom;
            for (k = 0; k < 60; k++) begin
                if ($urandom_range(0, 99) < 6)
                    value = $urandom;
                else
                    value = value + $urandom_range(0, 300);
                roll = $urandom_range(0, 99);
                if (roll < 4 || weff > 1000)
                    count = $urandom;
                else if (roll < 14)
                    count = $urandom_range(weff / 2, 2 * weff + 1);
                else
                    count = $urandom_range(0, (weff * 3) / 4 + 1);
                is_last = (k == 59) || ($urandom_range(0, 99) < 4);
                send_item(value, count, is_last);
                if (is_last)
                    value = $urandom;
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_item_value = '0;
        i_item_count = '0;
        i_item_last  = 1'b0;
        i_out_stall  = 1'b0;
        idle_on      = 1'b1;
        cfg.wish_depth   = edb_pkg::WISH_RESET;
        cfg.bucket_total = edb_pkg::TOTAL_RESET;
        cur_lo       = '0;
        cur_hi       = '0;
        cur_freq     = '0;
        cur_distinct = '0;
        cur_open     = 1'b0;
        n_closed     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_saturation();
        test_zero_settings();
        test_overshoot_rules();
        test_unsorted_input();
        test_bucket_clamp();
        test_random_ranges();
        wait_idle();

        $display("sent %0d items in %0d ranges across %0d register writes",
                 items_sent, ranges_sent, config_writes);
        $display("compared %0d buckets, %0d failures", buckets_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
